>>> rtl/sces_pkg.sv
// Shared types, widths and codes of the semi-cluster score engine.
package sces_pkg;

  localparam int FUNC_W     = 2;
  localparam int ID_W       = 32;
  localparam int WGT_W      = 16;
  localparam int SCORE_W    = 32;
  localparam int CNT_OUT_W  = 5;
  localparam int PEN_W      = 16;
  localparam int MAXM_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Numerator inner*2^12 - penalty*outer fits 49 signed bits, magnitude 48 bits
  localparam int NUM_W      = 49;
  localparam int MAG_W      = 48;
  localparam int PEN_FRAC   = 12;

  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EDGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_PENALTY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MEMBERS  = 1'd1;

  localparam logic [MAXM_W-1:0]  MAXM_RST  = 5'd16;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 32'h7FFF_FFFF;
  localparam logic [SCORE_W-1:0] SCORE_MIN = 32'h8000_0000;

  typedef logic [ID_W-1:0] vid_t;

  // Control broadcast from the sequencer to every member cell
  typedef struct packed {
    logic shift;  // move ids one cell up, new id enters cell 0
    logic probe;  // capture compare against the probe id
  } cell_ctrl_t;

endpackage

>>> rtl/sces_if.sv
// Request, result and configuration channel interfaces.
interface sces_in_if;
  logic                         valid;
  logic                         ready;
  logic [sces_pkg::FUNC_W-1:0]  func;
  logic [sces_pkg::ID_W-1:0]    vertex_id;
  logic signed [sces_pkg::WGT_W-1:0] weight;
  logic                         clear;
  logic                         last;

  modport source (output valid, func, vertex_id, weight, clear, last, input ready);
  modport sink   (input valid, func, vertex_id, weight, clear, last, output ready);
endinterface

interface sces_out_if;
  logic                             valid;
  logic                             ready;
  logic                             accepted;
  logic signed [sces_pkg::SCORE_W-1:0] score;
  logic [sces_pkg::CNT_OUT_W-1:0]   member_count;

  modport source (output valid, accepted, score, member_count, input ready);
  modport sink   (input valid, accepted, score, member_count, output ready);
endinterface

interface sces_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sces_pkg::CFG_IDX_W-1:0]   index;
  logic [sces_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/semi_cluster_score_engine.sv
// Top level of the semi-cluster score engine: member cell chain, edge sums, scoring.
// Member ids sit in a chain of MEMBER_DEPTH cells; a load with clear or with room left,
// or an accepted offer, shifts the new id into cell 0, and each cell compares its id
// with the request in parallel. A load, a stray edge or an unused code is done when it
// is accepted; an offer or an edge is compared when accepted, then updated. A rejected
// offer, or an accepted one with fewer than two members, is then emitted; any other
// scored result first passes the bit-serial divider, which produces one of 48 quotient
// bits per cycle. A request may be accepted while an earlier result still waits in the
// output register.
module semi_cluster_score_engine #(
  parameter int MEMBER_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sces_in_if.sink           in_i,
  sces_out_if.source        out_o,
  sces_cfg_if.sink          cfg_i
);
  import sces_pkg::*;

  localparam int CNT_W  = $clog2(MEMBER_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > MAXM_W) ? CNT_W : MAXM_W;
  localparam int PAIR_W = 2 * CNT_W;
  localparam int DIV_W  = PAIR_W + 4;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_NUM  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [WGT_W-1:0] w);
    logic signed [32:0] s;
    begin
      s = 33'(a) + 33'(w);
      if (s[32] != s[31]) begin
        sat_add = s[32] ? SCORE_MIN : SCORE_MAX;
      end else begin
        sat_add = s[31:0];
      end
    end
  endfunction

  logic [2:0]              state_q, state_d;
  logic [PEN_W-1:0]        pen_q;
  logic [MAXM_W-1:0]       maxm_q;
  logic [CNT_W-1:0]        count_q;
  logic signed [31:0]      inner_q, outer_q;
  logic                    pending_q;
  logic [FUNC_W-1:0]       op_func_q;
  vid_t                    op_id_q;
  logic signed [WGT_W-1:0] op_wgt_q;
  logic                    op_last_q;
  logic signed [NUM_W-1:0] prod_q;
  logic signed [NUM_W-1:0] pen_prod;
  logic [PAIR_W-1:0]       pairs_q;
  logic [PAIR_W-1:0]       nn_prod;
  logic signed [NUM_W-1:0] numer;
  logic [MAG_W-1:0]        mag_d;
  logic                    neg_q;
  logic                    res_acc_q;
  logic [SCORE_W-1:0]      res_score_q;
  logic [SCORE_W-1:0]      res_score_d;
  logic                    out_valid_q;
  logic                    out_acc_q;
  logic [SCORE_W-1:0]      out_score_q;
  logic [CNT_OUT_W-1:0]    out_cnt_q;

  logic                    in_acc;
  logic                    full;
  logic                    any_match;
  logic                    reject;
  logic                    emit_go;
  logic                    div_start;
  logic                    div_done;
  logic [MAG_W-1:0]        quotient;
  cell_ctrl_t              cell_ctrl;
  vid_t                    shift_id;
  vid_t                    cell_id   [MEMBER_DEPTH];
  logic [MEMBER_DEPTH-1:0] occupied;
  logic [MEMBER_DEPTH-1:0] match_vec;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign full = (CMP_W'(count_q) >= CMP_W'(maxm_q)) ||
                (count_q >= CNT_W'(MEMBER_DEPTH));
  assign any_match = |match_vec;
  assign reject    = full || any_match;
  assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);
  assign div_start = (state_q == ST_NUM);

  // cell chain control
  always_comb begin
    cell_ctrl.probe = in_acc;
    cell_ctrl.shift = (in_acc && in_i.func == FUNC_LOAD &&
                       (in_i.clear || count_q < CNT_W'(MEMBER_DEPTH))) ||
                      (state_q == ST_EVAL && op_func_q == FUNC_ADD && !reject);
    shift_id = (state_q == ST_EVAL) ? op_id_q : in_i.vertex_id;
  end

  // member cell chain
  for (genvar g = 0; g < MEMBER_DEPTH; g++) begin : g_cell
    vid_t prev_id;
    if (g == 0) begin : g_head
      assign prev_id = shift_id;
    end else begin : g_body
      assign prev_id = cell_id[g-1];
    end
    assign occupied[g] = CNT_W'(g) < count_q;

    sces_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .probe_i    (in_i.vertex_id),
      .prev_id_i  (prev_id),
      .occupied_i (occupied[g]),
      .id_o       (cell_id[g]),
      .match_o    (match_vec[g])
    );
  end

  // score arithmetic pieces
  always_comb begin
    pen_prod = $signed({1'b0, pen_q}) * outer_q;
    nn_prod  = PAIR_W'(count_q) * PAIR_W'(count_q - CNT_W'(1));
    numer    = (NUM_W'(inner_q) <<< PEN_FRAC) - prod_q;
    mag_d    = numer[NUM_W-1] ? MAG_W'(-numer) : MAG_W'(numer);
    if (|quotient[MAG_W-1:SCORE_W-1]) begin
      res_score_d = neg_q ? SCORE_MIN : SCORE_MAX;
    end else begin
      res_score_d = neg_q ? -quotient[SCORE_W-1:0] : quotient[SCORE_W-1:0];
    end
  end

  sces_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_d),
    .divisor_i  ({pairs_q, 4'b0000}),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.func == FUNC_ADD || (in_i.func == FUNC_EDGE && pending_q))) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (op_func_q == FUNC_ADD && reject) begin
          state_d = ST_EMIT;
        end else if (op_last_q) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL: begin
        state_d = (count_q < CNT_W'(2)) ? ST_EMIT : ST_NUM;
      end
      ST_NUM: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state: sequencer, cluster size, sums, pending flag, config, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pen_q       <= '0;
      maxm_q      <= MAXM_RST;
      count_q     <= '0;
      inner_q     <= '0;
      outer_q     <= '0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_EDGE_PENALTY: pen_q  <= cfg_i.data;
          CFG_MAX_MEMBERS:  maxm_q <= cfg_i.data[MAXM_W-1:0];
          default: begin
          end
        endcase
      end

      // member load
      if (in_acc && in_i.func == FUNC_LOAD) begin
        if (in_i.clear) begin
          count_q <= CNT_W'(1);
        end else if (count_q < CNT_W'(MEMBER_DEPTH)) begin
          count_q <= count_q + CNT_W'(1);
        end
        pending_q <= 1'b0;
        inner_q   <= '0;
        outer_q   <= '0;
      end

      // offer or edge update
      if (state_q == ST_EVAL) begin
        if (op_func_q == FUNC_ADD) begin
          inner_q   <= '0;
          outer_q   <= '0;
          pending_q <= !reject && !op_last_q;
          if (!reject) begin
            count_q <= count_q + CNT_W'(1);
          end
        end else begin
          if (any_match) begin
            inner_q <= sat_add(inner_q, op_wgt_q);
          end else begin
            outer_q <= sat_add(outer_q, op_wgt_q);
          end
          if (op_last_q) begin
            pending_q <= 1'b0;
          end
        end
      end

      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request latch, score pipeline and result registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_func_q <= in_i.func;
      op_id_q   <= in_i.vertex_id;
      op_wgt_q  <= in_i.weight;
      op_last_q <= in_i.last;
    end
    if (state_q == ST_EVAL) begin
      res_acc_q   <= 1'b0;
      res_score_q <= '0;
    end
    if (state_q == ST_MUL) begin
      prod_q      <= pen_prod;
      pairs_q     <= nn_prod >> 1;
      res_acc_q   <= 1'b1;
      res_score_q <= '0;
    end
    if (state_q == ST_NUM) begin
      neg_q <= numer[NUM_W-1];
    end
    if (state_q == ST_DIV && div_done) begin
      res_score_q <= res_score_d;
    end
    if (emit_go) begin
      out_acc_q   <= res_acc_q;
      out_score_q <= res_score_q;
      out_cnt_q   <= CNT_OUT_W'(count_q);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.accepted     = out_acc_q;
  assign out_o.score        = out_score_q;
  assign out_o.member_count = out_cnt_q;

endmodule

>>> rtl/sces_cell.sv
// One member cell: holds an id, passes it up the chain, compares it to a probe.
module sces_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sces_pkg::cell_ctrl_t  ctrl_i,
  input  sces_pkg::vid_t        probe_i,
  input  sces_pkg::vid_t        prev_id_i,
  input  logic                  occupied_i,
  output sces_pkg::vid_t        id_o,
  output logic                  match_o
);
  import sces_pkg::*;

  vid_t id_q;
  logic match_q;

  // id storage, shifted in from the lower neighbor
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      id_q <= prev_id_i;
    end
  end

  // registered membership hit, only for occupied cells
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.probe) begin
      match_q <= occupied_i && (id_q == probe_i);
    end
  end

  assign id_o    = id_q;
  assign match_o = match_q;

endmodule

>>> rtl/sces_div.sv
// Bit-serial restoring divider: unsigned magnitude by pair divisor, one bit per cycle.
module sces_div #(
  parameter int DIV_W = 14
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sces_pkg::MAG_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]           divisor_i,
  output logic                       done_o,
  output logic [sces_pkg::MAG_W-1:0] quotient_o
);
  import sces_pkg::*;

  localparam int CNT_W = $clog2(MAG_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] div_q;
  logic [DIV_W-1:0] rem_q;
  logic [DIV_W-1:0] rem_d;
  logic [MAG_W-1:0] quo_q;
  logic [DIV_W:0]   trial;
  logic             ge;

  // one trial subtraction per cycle
  always_comb begin
    trial = {rem_q, quo_q[MAG_W-1]};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? DIV_W'(trial - {1'b0, div_q}) : trial[DIV_W-1:0];
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNT_W'(MAG_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(MAG_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[MAG_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/sces_chk.sv
// Port-level checker for the semi-cluster score engine and its bind.
module sces_chk #(
  parameter int MEMBER_DEPTH = 16
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic [sces_pkg::FUNC_W-1:0]      in_func_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic                             out_accepted_i,
  input logic [sces_pkg::SCORE_W-1:0]     out_score_i,
  input logic [sces_pkg::CNT_OUT_W-1:0]   out_member_count_i
);
  import sces_pkg::*;

  // a result waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a rejected offer carries a zero score
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_accepted_i |-> out_score_i == '0)
    else $error("rejected offer with nonzero score");

  // a member load never causes a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_func_i == FUNC_LOAD |=> !$rose(out_valid_i))
    else $error("result after member load");

  // fewer than two members scores zero
  a_small_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_accepted_i && (MEMBER_DEPTH < 32) &&
    out_member_count_i < CNT_OUT_W'(2) |-> out_score_i == '0)
    else $error("nonzero score for fewer than two members");

endmodule

bind semi_cluster_score_engine sces_chk #(
  .MEMBER_DEPTH (MEMBER_DEPTH)
) u_sces_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .in_func_i          (in_i.func),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_accepted_i     (out_o.accepted),
  .out_score_i        (out_o.score),
  .out_member_count_i (out_o.member_count)
);

>>> test/semi_cluster_score_engine_tb.sv
// Self-checking testbench of the semi-cluster score engine: table-driven and random requests.
`timescale 1ns / 100ps

module semi_cluster_score_engine_tb;
  import sces_pkg::*;

  localparam int MEMBER_DEPTH = 16;
  localparam int SETTLE_CYC   = 64;        // longer than one scored result
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int PHASES       = 8;
  localparam int PHASE_REQS   = 78;
  localparam int RAND_PICK    = -1;
  localparam int SAT_REPS     = 16;        // with full penalty, boundary edges that clamp the score
  localparam longint Q_MAX    = 64'sd2147483647;
  localparam longint Q_MIN    = -64'sd2147483648;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic                      accepted;
    logic signed [SCORE_W-1:0] score;
    logic [CNT_OUT_W-1:0]      member_count;
  } cluster_result_t;

  typedef enum logic [1:0] {ROW_REQ, ROW_SET_PENALTY, ROW_SET_MAXM} row_kind_e;

  // One directed row: a request repeated reps times, or a register write (data in arg)
  typedef struct {
    row_kind_e            kind;
    logic [FUNC_W-1:0]    func;
    logic [ID_W-1:0]      arg;
    logic [WGT_W-1:0]     wgt;
    bit                   clr;
    bit                   lst;
    int                   reps;
    bit                   chk;
    bit                   eacc;
    logic [SCORE_W-1:0]   escore;
    logic [CNT_OUT_W-1:0] ecnt;
  } stim_row_t;

  stim_row_t dir_rows [32] = '{
    '{ROW_REQ, FUNC_EDGE, 32'h0, 16'h0, 0, 1, 1, 0, 0, 32'h0, 5'd0},  // stray edge
    '{ROW_REQ, FUNC_ADD, 32'hFFFF_FFFF, 16'h0, 0, 1, 1, 1, 1, 32'h0, 5'd1},
    '{ROW_REQ, FUNC_ADD, 32'hFFFF_FFFF, 16'h0, 0, 1, 1, 1, 0, 32'h0, 5'd1},  // duplicate
    '{ROW_REQ, FUNC_UNUSED, 32'h0, 16'h0, 0, 1, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_LOAD, 32'h0, 16'h0, 1, 0, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_LOAD, 32'h1, 16'h0, 0, 0, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_ADD, 32'h2, 16'h0, 0, 0, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_EDGE, 32'h0, 16'h7FFF, 0, 0, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_EDGE, 32'h2, 16'h8000, 0, 0, 1, 0, 0, 32'h0, 5'd0},  // edge to itself
    '{ROW_REQ, FUNC_EDGE, 32'hDEAD_BEEF, 16'h0100, 0, 1, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_SET_PENALTY, FUNC_LOAD, 32'hFFFF, 16'h0, 0, 0, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_ADD, 32'h3, 16'h0, 0, 0, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_ADD, 32'h4, 16'h0, 0, 1, 1, 1, 1, 32'h0, 5'd5},  // offer while pending
    '{ROW_REQ, FUNC_EDGE, 32'h4, 16'h0100, 0, 1, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_SET_MAXM, FUNC_LOAD, 32'h0, 16'h0, 0, 0, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_ADD, 32'h5, 16'h0, 0, 1, 1, 1, 0, 32'h0, 5'd5},
    '{ROW_SET_MAXM, FUNC_LOAD, 32'd31, 16'h0, 0, 0, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_LOAD, 32'h100, 16'h0, 0, 0, 12, 0, 0, 32'h0, 5'd0},  // one past depth
    '{ROW_REQ, FUNC_ADD, 32'h200, 16'h0, 0, 1, 1, 1, 0, 32'h0, 5'd16},
    '{ROW_SET_MAXM, FUNC_LOAD, 32'd16, 16'h0, 0, 0, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_LOAD, 32'h0, 16'h0, 1, 0, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_ADD, 32'h1, 16'h0, 0, 0, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_EDGE, 32'h9, 16'h8000, 0, 0, SAT_REPS, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_EDGE, 32'h9, 16'h8000, 0, 1, 1, 1, 1, SCORE_MAX, 5'd2},
    '{ROW_REQ, FUNC_LOAD, 32'h0, 16'h0, 1, 0, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_ADD, 32'h1, 16'h0, 0, 0, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_EDGE, 32'h9, 16'h7FFF, 0, 0, SAT_REPS, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_EDGE, 32'h9, 16'h7FFF, 0, 1, 1, 1, 1, SCORE_MIN, 5'd2},
    '{ROW_SET_PENALTY, FUNC_LOAD, 32'h0, 16'h0, 0, 0, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_ADD, 32'h7, 16'h0, 0, 0, 1, 0, 0, 32'h0, 5'd0},
    '{ROW_REQ, FUNC_LOAD, 32'h8, 16'h0, 0, 0, 1, 0, 0, 32'h0, 5'd0},  // drops the pending one
    '{ROW_REQ, FUNC_EDGE, 32'h8, 16'h0100, 0, 1, 1, 0, 0, 32'h0, 5'd0}
  };

  // Register settings per random phase
  int phase_pen [PHASES] = '{4096, 65535, 0, RAND_PICK, 1, RAND_PICK, 65535, RAND_PICK};
  int phase_mm  [PHASES] = '{16, 2, 16, 0, 31, 1, RAND_PICK, RAND_PICK};
  int send_idle_by_mode [4] = '{0, 56, 0, 18};
  int recv_stall_by_mode [4] = '{0, 0, 56, 18};

  logic clk_i;
  logic rst_ni;

  sces_in_if  req_if ();
  sces_out_if res_if ();
  sces_cfg_if cfg_if ();

  semi_cluster_score_engine #(
    .MEMBER_DEPTH(MEMBER_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  // Predicted cluster state and settings
  vid_t mem_ids [MEMBER_DEPTH];
  int   mem_cnt   = 0;
  int   inner_acc = 0;
  int   outer_acc = 0;
  bit   vtx_pend  = 1'b0;
  int unsigned pen_q412 = 0;
  int   max_mem   = 16;

  cluster_result_t expected_scores [$];

  int err_cnt   = 0;
  int res_cnt   = 0;
  int acc_cnt   = 0;
  int req_cnt   = 0;
  int cfg_cnt   = 0;
  int cycle_cnt = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_scores.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic bit in_cluster(vid_t id);
    for (int i = 0; i < mem_cnt; i++)
      if (mem_ids[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int add_clamped(int a, int b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > Q_MAX) return int'(Q_MAX);
    if (s < Q_MIN) return int'(Q_MIN);
    return int'(s);
  endfunction

  // (inner - penalty*outer) / pairs in Q24.8, penalty in Q4.12, truncated, then clamped
  function automatic logic signed [SCORE_W-1:0] cluster_score();
    longint n, pairs, numer, q;
    n = mem_cnt;
    if (n < 2) return '0;
    pairs = n * (n - 1) / 2;
    numer = longint'(inner_acc) * 4096 - longint'(pen_q412) * longint'(outer_acc);
    q = numer / (pairs * 16);
    if (q > Q_MAX) return SCORE_MAX;
    if (q < Q_MIN) return SCORE_MIN;
    return q[SCORE_W-1:0];
  endfunction

  // Applies one request to the predicted state; returns the result it causes, if any
  function automatic void predict_score(input logic [FUNC_W-1:0] f, input vid_t v,
                                        input logic [WGT_W-1:0] w, input logic c,
                                        input logic l, output bit has_res,
                                        output cluster_result_t res, output bit ign);
    has_res = 1'b0;
    ign     = 1'b0;
    res     = '0;
    case (f)
      FUNC_LOAD: begin
        if (c) mem_cnt = 0;
        if (mem_cnt < MEMBER_DEPTH) begin
          mem_ids[mem_cnt] = v;
          mem_cnt++;
        end
        vtx_pend  = 1'b0;
        inner_acc = 0;
        outer_acc = 0;
      end
      FUNC_ADD: begin
        vtx_pend  = 1'b0;
        inner_acc = 0;
        outer_acc = 0;
        has_res   = 1'b1;
        if (mem_cnt >= max_mem || mem_cnt >= MEMBER_DEPTH || in_cluster(v)) begin
          res = '{accepted: 1'b0, score: '0, member_count: CNT_OUT_W'(mem_cnt)};
        end else begin
          mem_ids[mem_cnt] = v;
          mem_cnt++;
          if (l) begin
            res = '{accepted: 1'b1, score: cluster_score(),
                    member_count: CNT_OUT_W'(mem_cnt)};
          end else begin
            has_res  = 1'b0;
            vtx_pend = 1'b1;
          end
        end
      end
      FUNC_EDGE: begin
        if (!vtx_pend) begin
          ign = 1'b1;
        end else begin
          if (in_cluster(v)) inner_acc = add_clamped(inner_acc, int'($signed(w)));
          else outer_acc = add_clamped(outer_acc, int'($signed(w)));
          if (l) begin
            vtx_pend = 1'b0;
            has_res  = 1'b1;
            res = '{accepted: 1'b1, score: cluster_score(),
                    member_count: CNT_OUT_W'(mem_cnt)};
          end
        end
      end
      default: ign = 1'b1;
    endcase
  endfunction

  // Sends one request, updates the prediction on acceptance
  task automatic issue_req(input logic [FUNC_W-1:0] f, input vid_t v,
                           input logic [WGT_W-1:0] w, input logic c, input logic l,
                           input bit chk, input cluster_result_t typed);
    bit has_res, ign;
    cluster_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     = 1'b1;
    req_if.func      = f;
    req_if.vertex_id = v;
    req_if.weight    = w;
    req_if.clear     = c;
    req_if.last      = l;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    req_if.valid = 1'b0;
    predict_score(f, v, w, c, l, has_res, res, ign);
    if (has_res) expected_scores.insert(expected_scores.size(), chk ? typed : res);
    if (!ign) req_cnt++;
  endtask

  // Register write, only once the engine has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    req_if.valid = 1'b0;
    while (expected_scores.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
    case (idx)
      CFG_EDGE_PENALTY: pen_q412 = data;
      CFG_MAX_MEMBERS:  max_mem = int'(data[MAXM_W-1:0]);
      default: ;
    endcase
    cfg_cnt++;
  endtask

  // Small ids collide with members often; full-width ids exercise every bit
  function automatic vid_t rand_id();
    if ($urandom_range(1) == 1) return vid_t'($urandom_range(63));
    return vid_t'($urandom);
  endfunction

  function automatic vid_t pick_member();
    if (mem_cnt == 0) return rand_id();
    return mem_ids[$urandom_range(mem_cnt - 1)];
  endfunction

  function automatic logic [WGT_W-1:0] rand_weight();
    int r;
    r = $urandom_range(99);
    if (r < 15) return r[0] ? 16'h7FFF : 16'h8000;
    if (r < 35) return WGT_W'($urandom_range(1023)) - 16'd512;
    return WGT_W'($urandom);
  endfunction

  // One cluster episode: optional reload, an offer, then its edges; some noise
  task automatic run_cluster();
    int   k, n_edges, r;
    vid_t vid, far_id;
    bit   broken;
    if ($urandom_range(99) < 12) begin
      issue_req(FUNC_W'($urandom_range(3)), rand_id(), WGT_W'($urandom),
                1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
      return;
    end
    if ($urandom_range(99) < 65) begin
      k = ($urandom_range(9) == 0) ? $urandom_range(6, 17) : $urandom_range(1, 5);
      for (int i = 0; i < k; i++)
        issue_req(FUNC_LOAD, rand_id(), WGT_W'($urandom), i == 0, 1'($urandom_range(1)),
                  1'b0, '0);
    end
    vid     = ($urandom_range(99) < 20) ? pick_member() : rand_id();
    n_edges = ($urandom_range(99) < 15) ? 0 : $urandom_range(1, 6);
    broken  = ($urandom_range(99) < 10);
    issue_req(FUNC_ADD, vid, WGT_W'($urandom), 1'b0, n_edges == 0, 1'b0, '0);
    for (int e = 0; e < n_edges; e++) begin
      r = $urandom_range(99);
      if (r < 45) far_id = pick_member();
      else if (r < 55) far_id = vid;
      else far_id = rand_id();
      issue_req(FUNC_EDGE, far_id, rand_weight(), 1'b0, (e == n_edges - 1) && !broken,
                1'b0, '0);
    end
  endtask

  // Result receiver with random stalls
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_diff(input string fld, input logic signed [31:0] exp_v,
                             input logic signed [31:0] act_v);
    err_cnt++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, exp_v, act_v);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    cluster_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_scores.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, got accepted %0b score %0d count %0d",
                 $time, res_if.accepted, res_if.score, res_if.member_count);
      end else begin
        want = expected_scores.pop_front();
        res_cnt++;
        if (want.accepted) acc_cnt++;
        if (res_if.accepted !== want.accepted)
          report_diff("accepted", 32'(want.accepted), 32'(res_if.accepted));
        if (res_if.score !== want.score)
          report_diff("score", want.score, res_if.score);
        if (res_if.member_count !== want.member_count)
          report_diff("member_count", 32'(want.member_count), 32'(res_if.member_count));
      end
    end
  end

  // Main sequence
  initial begin
    cluster_result_t typed;
    int pen_val, mm_val, phase_start;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.func      = FUNC_LOAD;
    req_if.vertex_id = '0;
    req_if.weight    = '0;
    req_if.clear     = 1'b0;
    req_if.last      = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_EDGE_PENALTY;
    cfg_if.data      = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows, no idling
    foreach (dir_rows[r]) begin
      case (dir_rows[r].kind)
        ROW_SET_PENALTY: write_reg(CFG_EDGE_PENALTY, dir_rows[r].arg[CFG_DATA_W-1:0]);
        ROW_SET_MAXM:    write_reg(CFG_MAX_MEMBERS, dir_rows[r].arg[CFG_DATA_W-1:0]);
        default: begin
          typed = '{accepted: dir_rows[r].eacc, score: dir_rows[r].escore,
                    member_count: dir_rows[r].ecnt};
          for (int j = 0; j < dir_rows[r].reps; j++)
            issue_req(dir_rows[r].func, dir_rows[r].arg, dir_rows[r].wgt, dir_rows[r].clr,
                      dir_rows[r].lst, dir_rows[r].chk, typed);
        end
      endcase
    end

    // Random phases, each with its own settings and idle pattern
    for (int p = 0; p < PHASES; p++) begin
      pen_val = (phase_pen[p] == RAND_PICK) ? int'($urandom_range(65535)) : phase_pen[p];
      mm_val  = (phase_mm[p] == RAND_PICK) ? int'($urandom_range(1, 16)) : phase_mm[p];
      write_reg(CFG_EDGE_PENALTY, CFG_DATA_W'(pen_val));
      write_reg(CFG_MAX_MEMBERS, CFG_DATA_W'(mm_val));
      send_idle_pct  = send_idle_by_mode[p % 4];
      recv_stall_pct = recv_stall_by_mode[p % 4];
      phase_start    = req_cnt;
      while (req_cnt - phase_start < PHASE_REQS) run_cluster();
    end

    // Drain
    req_if.valid = 1'b0;
    while (expected_scores.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);

    $display("Covered %0d requests: %0d directed rows, %0d random phases, %0d register writes",
             req_cnt, $size(dir_rows), PHASES, cfg_cnt);
    $display("Checked %0d results (%0d scored, rest rejected) under four idle patterns",
             res_cnt, acc_cnt);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sces_pkg.sv
rtl/sces_if.sv
rtl/sces_cell.sv
rtl/sces_div.sv
rtl/semi_cluster_score_engine.sv
rtl/sces_chk.sv
test/semi_cluster_score_engine_tb.sv
